### rtl/tdpt_pkg.sv
`default_nettype none

package tdpt_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int STEP_BITS   = 4;
    localparam int DIV_CYCLES  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS    = DIV_CYCLES * STEP_BITS;
    localparam int DIV_BITS    = VALUE_BITS / 2 + 2;
    localparam int SQ_BITS     = VALUE_BITS + 1;
    localparam int CNT_BITS    = $clog2(DIV_CYCLES);
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);

    localparam int FIRST_DIVISOR = 3;

    typedef struct packed {
        logic                  decided;
        logic                  verdict;
        logic [VALUE_BITS-1:0] value;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

endpackage

`default_nettype wire

### rtl/tdpt_front.sv
`default_nettype none

module tdpt_front
    import tdpt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [VALUE_BITS-1:0] i_candidate,
    input  wire logic                  i_full,
    output      logic                  o_busy,
    output      t_push                 o_push
);

    logic [VALUE_BITS-1:0] v;

    assign v      = i_candidate;
    assign o_busy = i_full || !i_rst_n;

    always_comb begin
        o_push.push          = i_start && !o_busy;
        o_push.entry.value   = v;
        o_push.entry.decided = 1'b1;
        o_push.entry.verdict = 1'b0;
        priority if (v[VALUE_BITS-1]) begin
            o_push.entry.verdict = 1'b0;
        end else if (v <= VALUE_BITS'(1)) begin
            o_push.entry.verdict = 1'b0;
        end else if (v == VALUE_BITS'(2)) begin
            o_push.entry.verdict = 1'b1;
        end else if (!v[0]) begin
            o_push.entry.verdict = 1'b0;
        end else begin
            o_push.entry.decided = 1'b0;
        end
    end

    // sign bit set means negative, never prime
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.push && i_candidate[VALUE_BITS-1]) |->
            (o_push.entry.decided && !o_push.entry.verdict))
        else $error("negative candidate not rejected");

endmodule

`default_nettype wire

### rtl/tdpt_queue.sv
`default_nettype none

module tdpt_queue
    import tdpt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_push  i_push,
    input  wire logic   i_pop,
    output      t_entry o_head,
    output      logic   o_empty,
    output      logic   o_full
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr;
    logic [PTR_BITS-1:0] r_rd;
    logic [PTR_BITS:0]   r_count;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (PTR_BITS+1)'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.push) begin
                r_wr <= r_wr + PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_BITS'(1);
            end
            unique case ({i_push.push, i_pop})
                2'b10:   r_count <= r_count + (PTR_BITS+1)'(1);
                2'b01:   r_count <= r_count - (PTR_BITS+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push |-> !o_full)
        else $error("push into full queue");

endmodule

`default_nettype wire

### rtl/tdpt_back.sv
`default_nettype none

module tdpt_back
    import tdpt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_entry i_head,
    input  wire logic   i_empty,
    output      logic   o_pop,
    output      logic   o_done,
    output      logic   o_is_prime
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV
    } t_state;

    t_state                r_state;
    logic [VALUE_BITS-1:0] r_value;
    logic [DIV_BITS-1:0]   r_div;
    logic [SQ_BITS-1:0]    r_sq;
    logic [PAD_BITS-1:0]   r_shift;
    logic [DIV_BITS-1:0]   r_rem;
    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_done;
    logic                  r_is_prime;

    logic [DIV_BITS-1:0]   n_rem;
    logic [PAD_BITS-1:0]   n_shift;
    logic [DIV_BITS:0]     rem_s;
    logic [SQ_BITS-1:0]    n_sq;
    logic                  last_step;

    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign o_done     = r_done;
    assign o_is_prime = r_is_prime;
    assign last_step  = (r_cnt == CNT_BITS'(DIV_CYCLES - 1));
    // (d+2)^2 = d^2 + 4d + 4
    assign n_sq = r_sq + SQ_BITS'({r_div, 2'b00}) + SQ_BITS'(4);

    // STEP_BITS restoring-remainder steps per cycle
    always_comb begin
        n_rem   = r_rem;
        n_shift = r_shift;
        rem_s   = '0;
        for (int k = 0; k < STEP_BITS; k++) begin
            rem_s   = {n_rem, n_shift[PAD_BITS-1]};
            n_shift = n_shift << 1;
            if (rem_s >= {1'b0, r_div}) begin
                rem_s = rem_s - {1'b0, r_div};
            end
            n_rem = rem_s[DIV_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_done     <= 1'b0;
            r_is_prime <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_value <= i_head.value;
                        r_div   <= DIV_BITS'(FIRST_DIVISOR);
                        r_sq    <= SQ_BITS'(FIRST_DIVISOR * FIRST_DIVISOR);
                        if (i_head.decided) begin
                            r_done     <= 1'b1;
                            r_is_prime <= i_head.verdict;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (r_sq > {1'b0, r_value}) begin
                        r_done     <= 1'b1;
                        r_is_prime <= 1'b1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_shift <= PAD_BITS'(r_value);
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem   <= n_rem;
                    r_shift <= n_shift;
                    r_cnt   <= r_cnt + CNT_BITS'(1);
                    if (last_step) begin
                        if (n_rem == '0) begin
                            r_done     <= 1'b1;
                            r_is_prime <= 1'b0;
                            r_state    <= S_IDLE;
                        end else begin
                            r_div   <= r_div + DIV_BITS'(2);
                            r_sq    <= n_sq;
                            r_state <= S_CHECK;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div[0] && r_rem < r_div))
        else $error("divisor even or remainder out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_sq <= {1'b0, r_value}))
        else $error("dividing past the square-root bound");

endmodule

`default_nettype wire

### rtl/trial_division_prime_test_top.sv
// Primality test by trial division. Raise i_start with a signed candidate while
// o_busy is low; o_done pulses for one cycle with o_is_prime, one per transaction,
// in order, and cannot be held off. Negative, zero, one, two and even candidates
// are settled in the front end and answered when the back end takes them from
// the queue. Odd candidates of 3 or more are divided by 3, 5, 7 and so on up to the
// square root; each divisor passes S_CHECK and then S_DIV, which takes 4
// remainder bits per cycle, so a 32-bit prime near the top of the range takes
// about 23170 divisors. A two-entry queue lets the front accept up to two
// transactions while the divider is busy; o_busy is high when that queue is full
// and while reset is held.
`default_nettype none

module trial_division_prime_test_top
    import tdpt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [VALUE_BITS-1:0] i_candidate,
    output      logic                  o_busy,
    output      logic                  o_done,
    output      logic                  o_is_prime
);

    t_push  push;
    t_entry head;
    logic   empty;
    logic   full;
    logic   pop;

    tdpt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_candidate (i_candidate),
        .i_full      (full),
        .o_busy      (o_busy),
        .o_push      (push)
    );

    tdpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    tdpt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_done     (o_done),
        .o_is_prime (o_is_prime)
    );

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tdpt_pkg::*;

    localparam int QUIET_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 76;
    localparam int SETTLE_CYCLES = 50;
    localparam int NUM_DIRECTED  = 24;

    localparam logic [VALUE_BITS-1:0] DIRECTED [NUM_DIRECTED] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15,
        32'd25, 32'd49, 32'd121, 32'd97, 32'd7919, 32'd65537, 32'd1018081,
        32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFD, 32'h8000_0000, 32'hFFFF_FFFF,
        32'hFFFF_FFF9, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFB
    };

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        int                    gap;
        bit                    drain;
    } t_candidate;

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic                  verdict;
    } t_verdict;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    logic [VALUE_BITS-1:0] i_candidate = '0;
    logic                  o_busy;
    logic                  o_done;
    logic                  o_is_prime;

    t_candidate queued_candidates[$];
    t_verdict   awaited_verdicts[$];
    int         mismatch_count = 0;
    int         quiet_cycles = 0;
    int         idle_left = 0;

    trial_division_prime_test_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_candidate (i_candidate),
        .o_busy      (o_busy),
        .o_done      (o_done),
        .o_is_prime  (o_is_prime)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // trial division at full width; sign bit set means not prime
    function automatic logic prime_verdict(logic [VALUE_BITS-1:0] cand);
        logic [63:0] n;
        logic [63:0] d;
        n = 64'(cand);
        if (cand[VALUE_BITS-1]) return 1'b0;
        if (n <= 1) return 1'b0;
        if (n == 2) return 1'b1;
        if (!n[0]) return 1'b0;
        for (d = 3; d <= n / d; d += 2) begin
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic add_candidate(logic [VALUE_BITS-1:0] value, int gap, bit drain);
        t_candidate c;
        c.value = value;
        c.gap   = gap;
        c.drain = drain;
        queued_candidates.push_back(c);
    endtask

    task automatic report_mismatch(string what, logic [VALUE_BITS-1:0] value,
                                   logic got, logic want);
        $display("MISMATCH %s: candidate %0d got %0b want %0b",
                 what, $signed(value), got, want);
        mismatch_count++;
    endtask

    function automatic logic [VALUE_BITS-1:0] random_candidate();
        int unsigned kind;
        logic [VALUE_BITS-1:0] m;
        kind = $urandom_range(0, 99);
        if (kind < 10) return $urandom | 32'h8000_0000;
        if (kind < 20) return $urandom & ~32'd1;
        if (kind < 25) return $urandom_range(0, 16);
        if (kind < 65) return $urandom_range(3, 4095) | 32'd1;
        if (kind < 85) return $urandom_range(4096, 65535) | 32'd1;
        if (kind < 95) return $urandom_range(65536, 1048575) | 32'd1;
        // large odd composite with a factor of three, exits on the first divisor
        m = $urandom_range(32'h2000_0000, 715_827_881) | 32'd1;
        return m * 3;
    endfunction

    always @(posedge i_clk) begin
        logic       launch;
        t_candidate c;
        t_verdict   v;
        if (!i_rst_n) begin
            i_start     <= 1'b0;
            i_candidate <= '0;
            idle_left = 0;
        end else begin
            launch = i_start;
            if (i_start && !o_busy) begin
                v.value   = i_candidate;
                v.verdict = prime_verdict(i_candidate);
                awaited_verdicts.push_back(v);
                launch = 1'b0;
                idle_left = (queued_candidates.size() > 0) ? queued_candidates[0].gap : 0;
            end
            if (!launch && queued_candidates.size() > 0) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else if (!(queued_candidates[0].drain && awaited_verdicts.size() != 0)) begin
                    c = queued_candidates.pop_front();
                    i_candidate <= c.value;
                    launch = 1'b1;
                end
            end
            i_start <= launch;
        end
    end

    always @(posedge i_clk) begin
        t_verdict v;
        if (i_rst_n && o_done) begin
            if (awaited_verdicts.size() == 0) begin
                report_mismatch("unexpected result", '0, o_is_prime, 1'bx);
            end else begin
                v = awaited_verdicts.pop_front();
                if (o_is_prime !== v.verdict) begin
                    report_mismatch("is_prime", v.value, o_is_prime, v.verdict);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("trial_division_prime_test_top verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int k = 0; k < NUM_DIRECTED; k++) begin
            add_candidate(DIRECTED[k], $urandom_range(0, 3), k == 12);
        end
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            // back-to-back burst in the middle, one full drain before it
            add_candidate(random_candidate(),
                          (k >= 40 && k < 60) ? 0 : $urandom_range(0, 3), k == 40);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_candidates.size() != 0 || i_start) @(posedge i_clk);
        while (awaited_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("trial_division_prime_test_top verification clean");
        end else begin
            $display("trial_division_prime_test_top verification failed");
        end
        $finish;
    end

endmodule
